// ----- design/cmpf_pkg.sv -----
`default_nettype none
package cmpf_pkg;

  localparam int REG_WIDTH   = 64;
  localparam int DATA_W      = 64;
  localparam int MAX_OP_SIZE = $clog2(REG_WIDTH / 8);

  // Command codes.
  localparam logic [3:0] CMD_CMP     = 4'd0;
  localparam logic [3:0] CMD_CMOV    = 4'd1;
  localparam logic [3:0] CMD_CMPXCHG = 4'd2;
  localparam logic [3:0] CMD_CBW     = 4'd3;
  localparam logic [3:0] CMD_CWD     = 4'd4;
  localparam logic [3:0] CMD_CLC     = 4'd5;
  localparam logic [3:0] CMD_CLD     = 4'd6;
  localparam logic [3:0] CMD_CLI     = 4'd7;
  localparam logic [3:0] CMD_CMC     = 4'd8;

  // Operand size codes.
  localparam logic [1:0] SZ_BYTE  = 2'd0;
  localparam logic [1:0] SZ_WORD  = 2'd1;
  localparam logic [1:0] SZ_DWORD = 2'd2;
  localparam logic [1:0] SZ_QWORD = 2'd3;

  // Flag bit positions.
  localparam int F_CF = 0;
  localparam int F_PF = 1;
  localparam int F_AF = 2;
  localparam int F_ZF = 3;
  localparam int F_SF = 4;
  localparam int F_OF = 5;
  localparam int F_DF = 6;
  localparam int F_IF = 7;

  typedef struct packed {
    logic [3:0]        cmd;
    logic [3:0]        cond;
    logic [1:0]        op_size;
    logic [1:0]        src_width;
    logic [DATA_W-1:0] dest_value;
    logic [DATA_W-1:0] src_value;
    logic [DATA_W-1:0] acc_value;
  } item_t;

  typedef struct packed {
    logic              dest_write;
    logic [DATA_W-1:0] dest_out;
    logic              acc_write;
    logic [DATA_W-1:0] acc_out;
    logic              rdx_write;
    logic [DATA_W-1:0] rdx_out;
    logic [1:0]        write_size;
    logic [7:0]        flags_out;
    logic              error;
  } result_t;

  function automatic logic [DATA_W-1:0] size_mask(input logic [1:0] sz);
    logic [DATA_W-1:0] m;
    unique case (sz)
      SZ_BYTE:  m = {{(DATA_W-8){1'b0}}, {8{1'b1}}};
      SZ_WORD:  m = {{(DATA_W-16){1'b0}}, {16{1'b1}}};
      SZ_DWORD: m = {{(DATA_W-32){1'b0}}, {32{1'b1}}};
      default:  m = {DATA_W{1'b1}};
    endcase
    return m;
  endfunction

  function automatic logic top_bit(input logic [DATA_W-1:0] v, input logic [1:0] sz);
    logic b;
    unique case (sz)
      SZ_BYTE:  b = v[7];
      SZ_WORD:  b = v[15];
      SZ_DWORD: b = v[31];
      default:  b = v[DATA_W-1];
    endcase
    return b;
  endfunction

  // Sign-extends v from size 'from' and truncates to size 'to'.
  function automatic logic [DATA_W-1:0] sext(input logic [DATA_W-1:0] v,
                                             input logic [1:0] from,
                                             input logic [1:0] to);
    logic [DATA_W-1:0] m;
    logic [DATA_W-1:0] r;
    m = size_mask(from);
    r = v & m;
    if (top_bit(v, from)) begin
      r = r | ~m;
    end
    return r & size_mask(to);
  endfunction

endpackage
`default_nettype wire

// ----- design/cmpf_exec.sv -----
`default_nettype none
module cmpf_exec (
  input  var cmpf_pkg::item_t   item,
  input  var logic [7:0]        flags,
  input  var logic              long_mode,
  output var cmpf_pkg::result_t res,
  output var logic [7:0]        flags_nxt
);
  import cmpf_pkg::*;

  logic              err;
  logic [DATA_W-1:0] m;
  logic [1:0]        ext_from;
  logic [DATA_W-1:0] sub_a;
  logic [DATA_W-1:0] sub_b;
  logic [DATA_W:0]   diff;
  logic [DATA_W-1:0] r;
  logic [7:0]        sub_f;
  logic              cc_t;
  logic              cc_ok;
  logic              eq;
  logic [1:0]        ext_size;

  always_comb begin
    err = 1'b0;
    if (item.cmd > CMD_CMC) begin
      err = 1'b1;
    end
    if (item.cmd <= CMD_CWD && item.op_size > MAX_OP_SIZE[1:0]) begin
      err = 1'b1;
    end
    if ((item.cmd == CMD_CBW || item.cmd == CMD_CWD) && item.op_size == SZ_BYTE) begin
      err = 1'b1;
    end
  end

  assign m        = size_mask(item.op_size);
  assign ext_from = (item.src_width < item.op_size) ? item.src_width : item.op_size;

  // One subtractor serves both cmp (dest - src) and cmpxchg (acc - dest).
  always_comb begin
    if (item.cmd == CMD_CMPXCHG) begin
      sub_a = item.acc_value & m;
      sub_b = item.dest_value & m;
    end else begin
      sub_a = item.dest_value & m;
      sub_b = sext(item.src_value, ext_from, item.op_size);
    end
  end

  assign diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign r    = diff[DATA_W-1:0] & m;
  assign eq   = (sub_a == sub_b);

  always_comb begin
    sub_f       = flags & ((8'd1 << F_DF) | (8'd1 << F_IF));
    sub_f[F_CF] = diff[DATA_W];
    sub_f[F_OF] = top_bit((sub_a ^ sub_b) & (sub_a ^ r), item.op_size);
    sub_f[F_AF] = sub_a[4] ^ sub_b[4] ^ r[4];
    sub_f[F_ZF] = (r == '0);
    sub_f[F_SF] = top_bit(r, item.op_size);
    sub_f[F_PF] = ~^r[7:0];
  end

  always_comb begin
    unique case (item.cond[3:1])
      3'd0:    cc_t = flags[F_OF];
      3'd1:    cc_t = flags[F_CF];
      3'd2:    cc_t = flags[F_ZF];
      3'd3:    cc_t = flags[F_CF] | flags[F_ZF];
      3'd4:    cc_t = flags[F_SF];
      3'd5:    cc_t = flags[F_PF];
      3'd6:    cc_t = flags[F_SF] ^ flags[F_OF];
      default: cc_t = flags[F_ZF] | (flags[F_SF] ^ flags[F_OF]);
    endcase
    cc_ok = item.cond[0] ? ~cc_t : cc_t;
  end

  // In long mode a dword sign extension lands as a full zero-extended qword.
  assign ext_size = (item.op_size == SZ_DWORD && long_mode) ? SZ_QWORD : item.op_size;

  always_comb begin
    res       = '0;
    flags_nxt = flags;
    if (!err) begin
      unique case (item.cmd)
        CMD_CMP: begin
          flags_nxt      = sub_f;
          res.write_size = item.op_size;
        end
        CMD_CMOV: begin
          if (cc_ok) begin
            res.dest_write = 1'b1;
            res.dest_out   = item.src_value & m;
          end
          res.write_size = item.op_size;
        end
        CMD_CMPXCHG: begin
          flags_nxt = sub_f;
          if (eq) begin
            res.dest_write = 1'b1;
            res.dest_out   = item.src_value & m;
          end else begin
            res.acc_write = 1'b1;
            res.acc_out   = item.dest_value & m;
          end
          res.write_size = item.op_size;
        end
        CMD_CBW: begin
          res.acc_write  = 1'b1;
          res.acc_out    = sext(item.acc_value, item.op_size - 2'd1, item.op_size);
          res.write_size = ext_size;
        end
        CMD_CWD: begin
          res.rdx_write  = 1'b1;
          res.rdx_out    = top_bit(item.acc_value, item.op_size) ? m : '0;
          res.write_size = ext_size;
        end
        CMD_CLC: flags_nxt[F_CF] = 1'b0;
        CMD_CLD: flags_nxt[F_DF] = 1'b0;
        CMD_CLI: flags_nxt[F_IF] = 1'b0;
        default: flags_nxt[F_CF] = ~flags[F_CF];
      endcase
    end
    res.flags_out = flags_nxt;
    res.error     = err;
  end

endmodule
`default_nettype wire

// ----- design/compare_cmov_flag_unit.sv -----
// An accepted input beat loads the input register at the accepting edge; its
// result loads the result register once that register is free or drains.
// Throughput: one instruction per cycle while the consumer keeps out_ready high;
// the flags register is updated as an instruction leaves the input register,
// so the next one sees the new flags.
// Reset (synchronous, rst_n low) clears both valid bits, the flags and long_mode.
`default_nettype none
module compare_cmov_flag_unit (
  input  var logic                      clk,
  input  var logic                      rst_n,
  input  var logic                      cfg_valid,
  output var logic                      cfg_ready,
  input  var logic                      cfg_long_mode,
  input  var logic                      in_valid,
  output var logic                      in_ready,
  input  var logic [3:0]                in_cmd,
  input  var logic [3:0]                in_cond,
  input  var logic [1:0]                in_op_size,
  input  var logic [1:0]                in_src_width,
  input  var logic [cmpf_pkg::DATA_W-1:0] in_dest_value,
  input  var logic [cmpf_pkg::DATA_W-1:0] in_src_value,
  input  var logic [cmpf_pkg::DATA_W-1:0] in_acc_value,
  output var logic                      out_valid,
  input  var logic                      out_ready,
  output var logic                      out_dest_write,
  output var logic [cmpf_pkg::DATA_W-1:0] out_dest_out,
  output var logic                      out_acc_write,
  output var logic [cmpf_pkg::DATA_W-1:0] out_acc_out,
  output var logic                      out_rdx_write,
  output var logic [cmpf_pkg::DATA_W-1:0] out_rdx_out,
  output var logic [1:0]                out_write_size,
  output var logic [7:0]                out_flags_out,
  output var logic                      out_error
);
  import cmpf_pkg::*;

  logic       long_mode_r;
  logic [7:0] flags_r;
  logic [7:0] flags_nxt;
  logic       s1_valid_r;
  item_t      s1_item_r;
  logic       out_valid_r;
  result_t    out_res_r;
  result_t    res_nxt;
  logic       advance;

  assign cfg_ready = 1'b1;

  // The input register moves on whenever the result register is free or drains.
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  cmpf_exec u_exec (
    .item      (s1_item_r),
    .flags     (flags_r),
    .long_mode (long_mode_r),
    .res       (res_nxt),
    .flags_nxt (flags_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_mode_r <= 1'b0;
      flags_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        long_mode_r <= cfg_long_mode;
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        flags_r     <= flags_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= '{cmd: in_cmd, cond: in_cond, op_size: in_op_size,
                     src_width: in_src_width, dest_value: in_dest_value,
                     src_value: in_src_value, acc_value: in_acc_value};
    end
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_dest_write = out_res_r.dest_write;
  assign out_dest_out   = out_res_r.dest_out;
  assign out_acc_write  = out_res_r.acc_write;
  assign out_acc_out    = out_res_r.acc_out;
  assign out_rdx_write  = out_res_r.rdx_write;
  assign out_rdx_out    = out_res_r.rdx_out;
  assign out_write_size = out_res_r.write_size;
  assign out_flags_out  = out_res_r.flags_out;
  assign out_error      = out_res_r.error;

endmodule
`default_nettype wire

// ----- design/cmpf_checker.sv -----
`default_nettype none
module cmpf_checker (
  input var logic       clk,
  input var logic       rst_n,
  input var logic       out_valid,
  input var logic       out_ready,
  input var logic       out_dest_write,
  input var logic       out_acc_write,
  input var logic       out_rdx_write,
  input var logic [1:0] out_write_size,
  input var logic       out_error
);
  import cmpf_pkg::*;

  // A result beat waiting on the consumer must stay up.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before acceptance");

  // A faulted instruction writes no register and reports zero write size.
  a_err_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |->
      !out_dest_write && !out_acc_write && !out_rdx_write && out_write_size == SZ_BYTE)
    else $error("error beat carries a register write");

  // At most one register is written by any single instruction.
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones({out_dest_write, out_acc_write, out_rdx_write}) <= 1)
    else $error("more than one register write in one beat");

  // Nothing comes out in the cycle right after reset is released.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind compare_cmov_flag_unit cmpf_checker u_cmpf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_dest_write (out_dest_write),
  .out_acc_write  (out_acc_write),
  .out_rdx_write  (out_rdx_write),
  .out_write_size (out_write_size),
  .out_error      (out_error)
);
`default_nettype wire
